@@ hdl/toeq_pkg.sv @@
// Package for the timestamp-ordered event queue: sizes, field widths,
// action and status codes, and the stored entry type.
// No dependencies.
`default_nettype none

package toeq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    localparam int ACT_W   = 2;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOT_DUE   = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   src_id;
        logic [TIME_W-1:0] due_time;
        logic              first_mark;
    } t_entry;

endpackage

`default_nettype wire

@@ hdl/toeq_if.sv @@
// Valid/ready channel interfaces for the event queue: request and response.
// Depends on toeq_pkg.
`default_nettype none

interface toeq_req_if;
    import toeq_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   source_id;
    logic [TIME_W-1:0] time_value;
    logic              first_flag;

    modport source (output valid, action, source_id, time_value, first_flag, input ready);
    modport sink   (input valid, action, source_id, time_value, first_flag, output ready);
endinterface

interface toeq_rsp_if;
    import toeq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_time;
    logic              out_first;

    modport source (output valid, status, out_id, out_time, out_first, input ready);
    modport sink   (input valid, status, out_id, out_time, out_first, output ready);
endinterface

`default_nettype wire

@@ hdl/timestamp_ordered_event_queue_top.sv @@
// Entries move one slot at a time through the entry memory.
//   insert: from the tail toward the head, each entry due later is copied one slot up,
//   then the new entry is placed; remove: scans from the head for the id, then shifts
//   later entries down; pop: takes a due head and shifts the rest; full, empty or invalid:
// status only. One request at a time; the next is taken once the result is staged.
// Reset (synchronous, active low) empties the queue; entry memory is not cleared.
`default_nettype none

module timestamp_ordered_event_queue_top (
    input  wire               i_clk,
    input  wire               i_rst_n,
    toeq_req_if.sink          i_req,
    toeq_rsp_if.source        o_rsp
);
    import toeq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PLACE,
        S_SH_READ,
        S_SH_WRITE,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [ACT_W-1:0]  r_act;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;
    logic              r_first;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_idx;
    t_status           r_status;
    t_entry            r_res;

    logic              r_out_valid;
    t_status           r_out_status;
    t_entry            r_out;

    t_entry            r_mem [QUEUE_DEPTH];
    t_entry            r_rdata;

    logic              n_we;
    logic [AW-1:0]     n_waddr;
    t_entry            n_wdata;
    logic [AW-1:0]     rd_addr;
    t_entry            new_entry;
    logic [CW-1:0]     idx_next;

    assign new_entry = '{src_id: r_id, due_time: r_time, first_mark: r_first};
    assign idx_next  = CW'(r_idx) + CW'(1);
    assign rd_addr   = (r_state == S_SH_READ) ? (r_idx + AW'(1)) : r_idx;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_id    = r_out.src_id;
    assign o_rsp.out_time  = r_out.due_time;
    assign o_rsp.out_first = r_out.first_mark;

    // Memory write port: shift-up during insert, placement, shift-down on removal and pop.
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_idx;
        n_wdata = r_rdata;
        unique case (r_state)
            S_EVAL: begin
                if (r_act == ACT_INSERT) begin
                    n_we    = 1'b1;
                    n_waddr = r_idx + AW'(1);
                    n_wdata = (r_rdata.due_time > r_time) ? r_rdata : new_entry;
                end
            end
            S_PLACE: begin
                n_we    = 1'b1;
                n_wdata = new_entry;
            end
            S_SH_WRITE: begin
                n_we    = 1'b1;
            end
            default: begin
                n_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FINISH restages the slot itself when it is freed
            if (r_out_valid && o_rsp.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_act    <= i_req.action;
                        r_id     <= i_req.source_id;
                        r_time   <= i_req.time_value;
                        r_first  <= i_req.first_flag;
                        r_res    <= '0;
                        r_status <= ST_OK;
                        r_idx    <= '0;
                        unique case (i_req.action)
                            ACT_INSERT: begin
                                if (r_count == CW'(QUEUE_DEPTH)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FINISH;
                                end else if (r_count == '0) begin
                                    r_state  <= S_PLACE;
                                end else begin
                                    r_idx    <= AW'(r_count - CW'(1));
                                    r_state  <= S_READ;
                                end
                            end
                            ACT_REMOVE: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state  <= S_READ;
                                end
                            end
                            ACT_POP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NOT_DUE;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state  <= S_READ;
                                end
                            end
                            default: begin
                                r_status <= ST_NOT_DUE;
                                r_state  <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    case (r_act)
                        ACT_INSERT: begin
                            // Later entry already copied one slot up this cycle
                            if (r_rdata.due_time > r_time) begin
                                if (r_idx == '0) begin
                                    r_state <= S_PLACE;
                                end else begin
                                    r_idx   <= r_idx - AW'(1);
                                    r_state <= S_READ;
                                end
                            end else begin
                                r_count <= r_count + CW'(1);
                                r_state <= S_FINISH;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_rdata.src_id == r_id) begin
                                r_state <= S_SH_READ;
                            end else if (idx_next == r_count) begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_FINISH;
                            end else begin
                                r_idx   <= r_idx + AW'(1);
                                r_state <= S_READ;
                            end
                        end
                        ACT_POP: begin
                            if (r_rdata.due_time <= r_time) begin
                                r_res   <= r_rdata;
                                r_state <= S_SH_READ;
                            end else begin
                                r_status <= ST_NOT_DUE;
                                r_state  <= S_FINISH;
                            end
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_PLACE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_FINISH;
                end
                S_SH_READ: begin
                    if (idx_next < r_count) begin
                        r_state <= S_SH_WRITE;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FINISH;
                    end
                end
                S_SH_WRITE: begin
                    r_idx   <= r_idx + AW'(1);
                    r_state <= S_SH_READ;
                end
                S_FINISH: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out        <= r_res;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/toeq_chk.sv @@
// Port-level checks for the event queue top level, attached by bind.
// Depends on toeq_pkg and timestamp_ordered_event_queue_top.
`default_nettype none

module toeq_chk (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_req_valid,
    input  wire                       i_req_ready,
    input  wire                       i_rsp_valid,
    input  wire                       i_rsp_ready,
    input  wire [toeq_pkg::STAT_W-1:0] i_status,
    input  wire [toeq_pkg::ID_W-1:0]   i_out_id,
    input  wire [toeq_pkg::TIME_W-1:0] i_out_time,
    input  wire                       i_out_first
);
    import toeq_pkg::*;

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_out_id) && $stable(i_out_time) && $stable(i_out_first))
        else $error("stalled response changed");

    // Only a successful pop carries entry data
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != ST_OK) |->
            (i_out_id == '0) && (i_out_time == '0) && (i_out_first == 1'b0))
        else $error("non-ok response carries data");

    // One item at a time: the block is busy right after a request transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

endmodule

bind timestamp_ordered_event_queue_top toeq_chk u_toeq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_out_id    (o_rsp.out_id),
    .i_out_time  (o_rsp.out_time),
    .i_out_first (o_rsp.out_first)
);

`default_nettype wire
